[sv/wsf_pkg.sv]
// Shared constants, job record type and helper functions of the weighted smoothing filter.
package wsf_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int PIX_W       = 8;
    localparam int POS_W       = 11;
    localparam int ADDR_W      = $clog2(MAX_WIDTH);
    localparam int SIZE_W      = 12;
    localparam int WEIGHT_W    = 3;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;
    localparam int SUM_W       = 13;
    localparam int RECIP_W     = 14;
    localparam int PROD_W      = SUM_W + RECIP_W;
    localparam int QUOT_SHIFT  = 17;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_WEIGHT = 2'd2;

    localparam logic [SIZE_W-1:0]   RST_WIDTH  = 12'd1920;
    localparam logic [SIZE_W-1:0]   RST_HEIGHT = 12'd1080;
    localparam logic [WEIGHT_W-1:0] RST_WEIGHT = 3'd4;
    localparam logic [SIZE_W-1:0]   MIN_SIZE   = 12'd3;
    localparam logic [WEIGHT_W-1:0] MIN_WEIGHT = 3'd4;

    // One job per input pixel that yields at least one result.
    typedef struct packed {
        logic [SUM_W-1:0]    sum;     // weighted neighbourhood sum
        logic [WEIGHT_W-1:0] weight;  // saturated centre weight
        logic [POS_W-1:0]    row;     // position of the input pixel
        logic [POS_W-1:0]    col;
        logic                inner;   // main result is a computed interior pixel
        logic                right;   // input closes its row
        logic                bottom;  // input lies on the last row
    } t_job;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] hi);
        logic [SIZE_W-1:0] res;
        res = v;
        if (v < MIN_SIZE) res = MIN_SIZE;
        else if (v > hi) res = hi;
        return res;
    endfunction

    function automatic logic [WEIGHT_W-1:0] sat_weight(input logic [WEIGHT_W-1:0] v);
        return (v < MIN_WEIGHT) ? MIN_WEIGHT : v;
    endfunction

    // ceil(2^17 / (weight + 12)); exact floor division for every reachable sum.
    function automatic logic [RECIP_W-1:0] recip(input logic [WEIGHT_W-1:0] wt);
        logic [RECIP_W-1:0] m;
        case (wt)
            3'd5:    m = 14'd7711;
            3'd6:    m = 14'd7282;
            3'd7:    m = 14'd6899;
            default: m = 14'd8192;
        endcase
        return m;
    endfunction

endpackage

[sv/wsf_pix_if.sv]
// Input channel carrying one grayscale pixel per beat.
interface wsf_pix_if;
    logic                      valid;
    logic                      ready;
    logic [wsf_pkg::PIX_W-1:0] pixel_in;
    logic                      frame_start;

    modport source (output valid, output pixel_in, output frame_start, input ready);
    modport sink   (input valid, input pixel_in, input frame_start, output ready);
endinterface

[sv/wsf_res_if.sv]
// Output channel carrying one filtered pixel with its coordinates per beat.
interface wsf_res_if;
    logic                      valid;
    logic                      ready;
    logic [wsf_pkg::PIX_W-1:0] pixel_out;
    logic [wsf_pkg::POS_W-1:0] out_row;
    logic [wsf_pkg::POS_W-1:0] out_col;
    logic                      run_last;
    logic                      frame_done;

    modport source (output valid, output pixel_out, output out_row, output out_col,
                    output run_last, output frame_done, input ready);
    modport sink   (input valid, input pixel_out, input out_row, input out_col,
                    input run_last, input frame_done, output ready);
endinterface

[sv/wsf_front.sv]
// Front part: position tracking, line buffers, window and weighted sum per pixel.
module wsf_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [wsf_pkg::SIZE_W-1:0]        i_width,
    input  logic [wsf_pkg::SIZE_W-1:0]        i_height,
    input  logic [wsf_pkg::WEIGHT_W-1:0]      i_weight,
    wsf_pix_if.sink                           i_pix,
    output logic                              o_push,
    output wsf_pkg::t_job                     o_job,
    input  logic                              i_full
);

    localparam int LINE_W = 2 * wsf_pkg::PIX_W;

    logic [wsf_pkg::POS_W-1:0]  r_row, r_col, n_row, n_col;
    logic [wsf_pkg::POS_W-1:0]  cur_r, cur_c;
    logic                       restart, accept;
    logic [wsf_pkg::SIZE_W-1:0] row_inc, col_inc;

    logic                       r_s1_valid;
    logic [wsf_pkg::POS_W-1:0]  r_s1_r, r_s1_c;
    logic [wsf_pkg::PIX_W-1:0]  r_s1_pix;
    logic                       r_hit;
    logic [LINE_W-1:0]          r_fwd, r_ram_q, s1_line;
    logic [wsf_pkg::PIX_W-1:0]  s1_top, s1_mid;
    logic                       s1_main, s1_need, s1_go, s1_adv;
    logic [wsf_pkg::PIX_W-1:0]  r_win [6];
    logic [wsf_pkg::SUM_W-1:0]  s1_sum;
    logic [LINE_W-1:0]          mem [wsf_pkg::MAX_WIDTH];

    // Position of the incoming pixel.
    assign restart = i_pix.frame_start || ({1'b0, r_row} >= i_height)
                     || ({1'b0, r_col} >= i_width);
    assign cur_r = restart ? '0 : r_row;
    assign cur_c = restart ? '0 : r_col;
    assign row_inc = {1'b0, cur_r} + 12'd1;
    assign col_inc = {1'b0, cur_c} + 12'd1;

    always_comb begin
        if (col_inc >= i_width) begin
            n_col = '0;
            n_row = (row_inc >= i_height) ? '0 : row_inc[wsf_pkg::POS_W-1:0];
        end else begin
            n_col = col_inc[wsf_pkg::POS_W-1:0];
            n_row = cur_r;
        end
    end

    // Second stage: the line buffer word, forwarded when the previous pixel wrote it.
    assign s1_line = r_hit ? r_fwd : r_ram_q;
    assign s1_top  = s1_line[LINE_W-1:wsf_pkg::PIX_W];
    assign s1_mid  = s1_line[wsf_pkg::PIX_W-1:0];
    assign s1_main = (r_s1_r != '0) && (r_s1_c != '0);
    assign s1_need = r_s1_valid && s1_main;
    assign s1_go   = !s1_need || !i_full;
    assign s1_adv  = r_s1_valid && s1_go;

    assign i_pix.ready = !r_s1_valid || s1_go;
    assign accept      = i_pix.valid && i_pix.ready;

    assign s1_sum = wsf_pkg::SUM_W'(r_win[0]) + wsf_pkg::SUM_W'(r_win[2])
                  + wsf_pkg::SUM_W'(s1_top) + wsf_pkg::SUM_W'(r_s1_pix)
                  + wsf_pkg::SUM_W'({r_win[1], 1'b0}) + wsf_pkg::SUM_W'({r_win[3], 1'b0})
                  + wsf_pkg::SUM_W'({r_win[5], 1'b0}) + wsf_pkg::SUM_W'({s1_mid, 1'b0})
                  + wsf_pkg::SUM_W'(i_weight) * wsf_pkg::SUM_W'(r_win[4]);

    assign o_push        = s1_need && !i_full;
    assign o_job.sum     = s1_sum;
    assign o_job.weight  = i_weight;
    assign o_job.row     = r_s1_r;
    assign o_job.col     = r_s1_c;
    assign o_job.inner   = (r_s1_r >= 11'd2) && (r_s1_c >= 11'd2);
    assign o_job.right   = ({1'b0, r_s1_c} == i_width - 12'd1);
    assign o_job.bottom  = ({1'b0, r_s1_r} == i_height - 12'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row      <= '0;
            r_col      <= '0;
            r_s1_valid <= 1'b0;
            for (int k = 0; k < 6; k++) r_win[k] <= '0;
        end else begin
            if (accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
            if (accept) r_s1_valid <= 1'b1;
            else if (s1_adv) r_s1_valid <= 1'b0;
            if (s1_adv) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= s1_top;
                r_win[4] <= s1_mid;
                r_win[5] <= r_s1_pix;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_r   <= cur_r;
            r_s1_c   <= cur_c;
            r_s1_pix <= i_pix.pixel_in;
            r_hit    <= r_s1_valid && (cur_c == r_s1_c);
            r_fwd    <= {s1_mid, r_s1_pix};
            r_ram_q  <= mem[cur_c];
        end
        if (s1_adv) mem[r_s1_c] <= {s1_mid, r_s1_pix};
    end

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted pixel did not reach the second stage");

    a_push_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (r_s1_r != '0) && (r_s1_c != '0))
        else $error("job pushed for a pixel on the first row or column");

endmodule

[sv/wsf_queue.sv]
// Short job queue between the front and back parts.
module wsf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  wsf_pkg::t_job i_job,
    output logic          o_full,
    output logic          o_valid,
    output wsf_pkg::t_job o_head,
    input  logic          i_pop
);

    wsf_pkg::t_job               r_mem [wsf_pkg::QUEUE_DEPTH];
    logic [wsf_pkg::QPTR_W-1:0]  r_wp, r_rp;
    logic [wsf_pkg::QCNT_W-1:0]  r_count;

    assign o_full  = (r_count == wsf_pkg::QCNT_W'(wsf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + wsf_pkg::QPTR_W'(1);
            if (i_pop)  r_rp <= r_rp + wsf_pkg::QPTR_W'(1);
            if (i_push && !i_pop) r_count <= r_count + wsf_pkg::QCNT_W'(1);
            else if (i_pop && !i_push) r_count <= r_count - wsf_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid)
        else $error("job queue read while empty");

endmodule

[sv/wsf_back.sv]
// Back part: division by the kernel weight total and emission of the results of each job.
module wsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  wsf_pkg::t_job i_head,
    output logic          o_pop,
    wsf_res_if.source     o_res
);

    typedef enum logic [1:0] {
        ST_MAIN,
        ST_RIGHT,
        ST_BOTTOM,
        ST_CORNER
    } t_step;

    t_step                       r_step, n_step;
    logic                        r_busy, r_inner, r_right, r_bottom;
    logic [wsf_pkg::PROD_W-1:0]  r_prod;
    logic [wsf_pkg::POS_W-1:0]   r_row, r_col;
    logic                        last, emit, load;
    logic [wsf_pkg::PIX_W-1:0]   e_pix, quot;
    logic [wsf_pkg::POS_W-1:0]   e_row, e_col;
    logic                        e_done;

    logic                        r_ovalid, r_olast, r_odone;
    logic [wsf_pkg::PIX_W-1:0]   r_opix;
    logic [wsf_pkg::POS_W-1:0]   r_orow, r_ocol;

    assign quot = r_prod[wsf_pkg::QUOT_SHIFT +: wsf_pkg::PIX_W];

    always_comb begin
        n_step = ST_MAIN;
        last   = 1'b1;
        e_pix  = '0;
        e_row  = r_row;
        e_col  = r_col;
        e_done = 1'b0;
        case (r_step)
            ST_MAIN: begin
                e_pix = r_inner ? quot : '0;
                e_row = r_row - 11'd1;
                e_col = r_col - 11'd1;
                if (r_right) begin
                    n_step = ST_RIGHT;
                    last   = 1'b0;
                end else if (r_bottom) begin
                    n_step = ST_BOTTOM;
                    last   = 1'b0;
                end
            end
            ST_RIGHT: begin
                e_row = r_row - 11'd1;
                if (r_bottom) begin
                    n_step = ST_BOTTOM;
                    last   = 1'b0;
                end
            end
            ST_BOTTOM: begin
                e_col = r_col - 11'd1;
                if (r_right) begin
                    n_step = ST_CORNER;
                    last   = 1'b0;
                end
            end
            ST_CORNER: begin
                e_done = 1'b1;
            end
            default: begin
                e_done = 1'b0;
            end
        endcase
    end

    assign emit  = r_busy && (!r_ovalid || o_res.ready);
    assign load  = !r_busy || (emit && last);
    assign o_pop = load && i_head_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_step   <= ST_MAIN;
            r_ovalid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= i_head_valid;
                r_step <= ST_MAIN;
            end else if (emit) begin
                r_step <= n_step;
            end
            if (emit) r_ovalid <= 1'b1;
            else if (o_res.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod   <= wsf_pkg::PROD_W'(i_head.sum)
                        * wsf_pkg::PROD_W'(wsf_pkg::recip(i_head.weight));
            r_row    <= i_head.row;
            r_col    <= i_head.col;
            r_inner  <= i_head.inner;
            r_right  <= i_head.right;
            r_bottom <= i_head.bottom;
        end
        if (emit) begin
            r_opix  <= e_pix;
            r_orow  <= e_row;
            r_ocol  <= e_col;
            r_olast <= last;
            r_odone <= e_done;
        end
    end

    assign o_res.valid      = r_ovalid;
    assign o_res.pixel_out  = r_opix;
    assign o_res.out_row    = r_orow;
    assign o_res.out_col    = r_ocol;
    assign o_res.run_last   = r_olast;
    assign o_res.frame_done = r_odone;

    a_done_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && r_odone |-> r_olast)
        else $error("frame end flagged on a result that is not the last of its pixel");

    a_pop_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy || (emit && last))
        else $error("job taken while the previous one is still being emitted");

endmodule

[sv/weighted_3x3_smoothing_filter_unit.sv]
// Top level of the weighted 3x3 smoothing filter: configuration registers and the three parts.
//
//  Channel   Direction  Beat contents
//  i_pix     in         pixel_in (8 bit), frame_start (1 bit)
//  o_res     out        pixel_out (8), out_row (11), out_col (11), run_last, frame_done
//  i_cfg_*   in         write enable, register index (2 bit), write data (12 bit)
//
// A pixel is taken every cycle while the job queue has room. The line buffer is read at
// the accepting edge and the weighted sum is formed in the following cycle, so the job
// enters the queue from the second stage once the queue has room. The back part emits
// one result per cycle while the output is ready; a pixel closing a row or lying on the
// last row yields two to four results, and the four-entry queue soaks up those bursts.
// Reset is synchronous and clears counters, window, handshake state and configuration
// registers; the line buffers are not cleared. A stalled output holds its beat
// while the front keeps accepting until the queue fills.
module weighted_3x3_smoothing_filter_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [wsf_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [wsf_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    wsf_pix_if.sink                              i_pix,
    wsf_res_if.source                            o_res
);

    // Raw register contents, saturated below before use.
    logic [wsf_pkg::SIZE_W-1:0]   r_width, r_height;
    logic [wsf_pkg::WEIGHT_W-1:0] r_weight;
    logic [wsf_pkg::SIZE_W-1:0]   width_c, height_c;
    logic [wsf_pkg::WEIGHT_W-1:0] weight_c;

    logic          push, full, head_valid, pop;
    wsf_pkg::t_job push_job, head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= wsf_pkg::RST_WIDTH;
            r_height <= wsf_pkg::RST_HEIGHT;
            r_weight <= wsf_pkg::RST_WEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wsf_pkg::CFG_IMAGE_WIDTH:   r_width  <= i_cfg_data;
                wsf_pkg::CFG_IMAGE_HEIGHT:  r_height <= i_cfg_data;
                wsf_pkg::CFG_CENTER_WEIGHT: r_weight <= i_cfg_data[wsf_pkg::WEIGHT_W-1:0];
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    // Sizes outside the supported range behave as the nearest supported size.
    assign width_c  = wsf_pkg::clamp_size(r_width, wsf_pkg::SIZE_W'(wsf_pkg::MAX_WIDTH));
    assign height_c = wsf_pkg::clamp_size(r_height, wsf_pkg::SIZE_W'(wsf_pkg::MAX_HEIGHT));
    assign weight_c = wsf_pkg::sat_weight(r_weight);

    // The front part tracks the raster position and forms the 3x3 sum.
    wsf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_width  (width_c),
        .i_height (height_c),
        .i_weight (weight_c),
        .i_pix    (i_pix),
        .o_push   (push),
        .o_job    (push_job),
        .i_full   (full)
    );

    wsf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (full),
        .o_valid (head_valid),
        .o_head  (head_job),
        .i_pop   (pop)
    );

    // The back part divides and emits the border zeros that each pixel triggers.
    wsf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head_job),
        .o_pop        (pop),
        .o_res        (o_res)
    );

endmodule

[dv/tb.sv]
// Self-checking testbench of the weighted 3x3 smoothing filter with its own pixel-level predictor.
`timescale 1ns / 1ps

// One filtered pixel as it leaves the block.
typedef struct {
    logic [wsf_pkg::PIX_W-1:0] pixel_out;
    logic [wsf_pkg::POS_W-1:0] out_row;
    logic [wsf_pkg::POS_W-1:0] out_col;
    logic                      run_last;
    logic                      frame_done;
} t_smooth_beat;

// Tracks the frame position, line stores and window of the filter and holds the pixels
// still owed by the block, oldest first.
class smoothed_frame_tracker;
    localparam int unsigned WEIGHT_BIAS = 12;

    logic [wsf_pkg::SIZE_W-1:0]   width_reg;
    logic [wsf_pkg::SIZE_W-1:0]   height_reg;
    logic [wsf_pkg::WEIGHT_W-1:0] weight_reg;
    logic [wsf_pkg::PIX_W-1:0]    row_above     [wsf_pkg::MAX_WIDTH];
    logic [wsf_pkg::PIX_W-1:0]    row_two_above [wsf_pkg::MAX_WIDTH];
    logic [wsf_pkg::PIX_W-1:0]    window        [6];
    int unsigned                  next_row;
    int unsigned                  next_col;
    t_smooth_beat                 awaited_pixels [$];
    int                           errors;

    function new();
        width_reg  = wsf_pkg::RST_WIDTH;
        height_reg = wsf_pkg::RST_HEIGHT;
        weight_reg = wsf_pkg::RST_WEIGHT;
        foreach (row_above[i]) begin
            row_above[i]     = '0;
            row_two_above[i] = '0;
        end
        foreach (window[i]) window[i] = '0;
        next_row = 0;
        next_col = 0;
        errors   = 0;
    endfunction

    function int unsigned bound_size(input logic [wsf_pkg::SIZE_W-1:0] v,
                                     input int unsigned hi);
        if (v < wsf_pkg::MIN_SIZE) return wsf_pkg::MIN_SIZE;
        if (v > hi) return hi;
        return v;
    endfunction

    function void write_reg(input logic [wsf_pkg::CFG_IDX_W-1:0] idx,
                            input logic [wsf_pkg::CFG_DATA_W-1:0] data);
        case (idx)
            wsf_pkg::CFG_IMAGE_WIDTH:   width_reg  = data;
            wsf_pkg::CFG_IMAGE_HEIGHT:  height_reg = data;
            wsf_pkg::CFG_CENTER_WEIGHT: weight_reg = data[wsf_pkg::WEIGHT_W-1:0];
            default: ;
        endcase
    endfunction

    function t_smooth_beat make_beat(input int unsigned value, input int unsigned row,
                                     input int unsigned col, input bit done);
        t_smooth_beat beat;
        beat.pixel_out  = value[wsf_pkg::PIX_W-1:0];
        beat.out_row    = row[wsf_pkg::POS_W-1:0];
        beat.out_col    = col[wsf_pkg::POS_W-1:0];
        beat.run_last   = 1'b0;
        beat.frame_done = done;
        return beat;
    endfunction

    // Works out every pixel that one accepted input releases and advances the position.
    function void take_pixel(input logic [wsf_pkg::PIX_W-1:0] pix, input logic fs);
        int unsigned  w, h, cw, r, c, sum, val;
        logic [wsf_pkg::PIX_W-1:0] top, mid;
        t_smooth_beat burst [$];
        w  = bound_size(width_reg, wsf_pkg::MAX_WIDTH);
        h  = bound_size(height_reg, wsf_pkg::MAX_HEIGHT);
        cw = (weight_reg < wsf_pkg::MIN_WEIGHT) ? wsf_pkg::MIN_WEIGHT : weight_reg;
        if (fs || next_row >= h || next_col >= w) begin
            next_row = 0;
            next_col = 0;
        end
        r   = next_row;
        c   = next_col;
        top = row_two_above[c];
        mid = row_above[c];

        if (r >= 1 && c >= 1) begin
            val = 0;
            if (r >= 2 && c >= 2) begin
                sum = window[0] + 2 * window[3] + top +
                      2 * window[1] + cw * window[4] + 2 * mid +
                      window[2] + 2 * window[5] + pix;
                val = sum / (cw + WEIGHT_BIAS);
            end
            burst.push_back(make_beat(val, r - 1, c - 1, 1'b0));
            if (c == w - 1) burst.push_back(make_beat(0, r - 1, w - 1, 1'b0));
        end
        if (r == h - 1 && c >= 1) begin
            burst.push_back(make_beat(0, h - 1, c - 1, 1'b0));
            if (c == w - 1) burst.push_back(make_beat(0, h - 1, w - 1, 1'b1));
        end
        if (burst.size() > 0) burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i]) awaited_pixels.push_back(burst[i]);

        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = pix;
        row_two_above[c] = mid;
        row_above[c]     = pix;

        if (c + 1 >= w) begin
            next_col = 0;
            next_row = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            next_col = c + 1;
        end
    endfunction

    function void compare_field(input string name, input logic [15:0] want, input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    function void match_pixel(input t_smooth_beat got);
        t_smooth_beat want;
        if (awaited_pixels.size() == 0) begin
            $error("unexpected pixel at row %0d col %0d", got.out_row, got.out_col);
            errors++;
            return;
        end
        want = awaited_pixels.pop_front();
        compare_field("pixel_out",  want.pixel_out,  got.pixel_out);
        compare_field("out_row",    want.out_row,    got.out_row);
        compare_field("out_col",    want.out_col,    got.out_col);
        compare_field("run_last",   want.run_last,   got.run_last);
        compare_field("frame_done", want.frame_done, got.frame_done);
    endfunction

    function int pending();
        return awaited_pixels.size();
    endfunction
endclass

module tb;

    // Longest idle draw of either side, per beat.
    localparam int IDLE_MAX       = 14;
    // Cycles allowed for pixels still in the front part to clear once nothing is owed;
    // the front holds one pixel in its second stage and the queue four entries, so this is ample.
    localparam int SETTLE_CYCLES  = 12;
    // Worst correct run is a few hundred pixels plus the drains; the timeout is set far
    // above that.
    localparam int TIMEOUT_CYCLES = 400_000;
    localparam int RANDOM_ITEMS   = 300;
    // The index that names no register; a write to it must change nothing.
    localparam logic [wsf_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum int {PAT_RANDOM, PAT_WHITE, PAT_BLACK, PAT_SPECKLE} t_pattern;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [wsf_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [wsf_pkg::CFG_DATA_W-1:0] i_cfg_data;

    wsf_pix_if pix_ch ();
    wsf_res_if res_ch ();

    weighted_3x3_smoothing_filter_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (pix_ch),
        .o_res      (res_ch)
    );

    smoothed_frame_tracker frame_tracker;

    // When set, the matching side takes every beat without idling.
    bit          sender_no_idle;
    bit          receiver_no_idle;
    // Set when the frame has been widened; the next pixel must then open a new frame so
    // that no line store entry is read before it has been written.
    bit          widen_pending;
    int unsigned cycle_count = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= TIMEOUT_CYCLES) begin
            $display("tb: FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(input bit no_idle);
        if (no_idle) return 0;
        return $urandom_range(0, IDLE_MAX);
    endfunction

    function automatic logic [wsf_pkg::PIX_W-1:0] pick_pixel(input t_pattern pattern);
        case (pattern)
            PAT_WHITE:   return 8'hFF;
            PAT_BLACK:   return 8'h00;
            PAT_SPECKLE: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            default:     return wsf_pkg::PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    // Offers one pixel after a random gap and waits for the beat to be taken. Valid is
    // only lowered when a gap follows, so back-to-back beats keep it high throughout.
    task automatic send_pixel(input logic [wsf_pkg::PIX_W-1:0] value, input logic fs);
        int gap;
        gap = draw_gap(sender_no_idle);
        if (gap > 0) begin
            pix_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_ch.valid       <= 1'b1;
        pix_ch.pixel_in    <= value;
        pix_ch.frame_start <= fs;
        do @(posedge i_clk); while (!pix_ch.ready);
        frame_tracker.take_pixel(value, fs);
        if (fs) widen_pending = 1'b0;
    endtask

    // Stops offering pixels until every owed result has left, then lets the front part
    // clear of pixels that release nothing.
    task automatic drain_results();
        pix_ch.valid <= 1'b0;
        do @(posedge i_clk); while (frame_tracker.pending() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Register write; only ever called while the block is idle.
    task automatic write_cfg(input logic [wsf_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wsf_pkg::CFG_DATA_W-1:0] data);
        if (idx == wsf_pkg::CFG_IMAGE_WIDTH &&
            frame_tracker.bound_size(data, wsf_pkg::MAX_WIDTH) >
            frame_tracker.bound_size(frame_tracker.width_reg, wsf_pkg::MAX_WIDTH))
            widen_pending = 1'b1;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        frame_tracker.write_reg(idx, data);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Sends a run of raster-order pixels. Frame starts mark each full frame, the first only when
    // first_fs or widen_pending is set; with noise_odds above zero, a stray frame start appears
    // about once in that many pixels, and about once in eighty the sender waits for a drain.
    task automatic send_run(input int w, input int h, input int len, input t_pattern pattern,
                            input bit first_fs, input int noise_odds);
        logic fs;
        for (int k = 0; k < len; k++) begin
            fs = ((k % (w * h)) == 0) && (k > 0 || first_fs || widen_pending);
            if (noise_odds > 0 && $urandom_range(1, noise_odds) == 1) fs = 1'b1;
            if (k > 0 && $urandom_range(0, 79) == 0) drain_results();
            send_pixel(pick_pixel(pattern), fs);
        end
    endtask

    // Result side: stalls at random, takes each beat and checks it against the oldest
    // owed pixel. Ready is only lowered when a stall follows.
    initial begin : result_sink
        t_smooth_beat beat;
        int           stall;
        res_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = draw_gap(receiver_no_idle);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!res_ch.valid);
            beat.pixel_out  = res_ch.pixel_out;
            beat.out_row    = res_ch.out_row;
            beat.out_col    = res_ch.out_col;
            beat.run_last   = res_ch.run_last;
            beat.frame_done = res_ch.frame_done;
            frame_tracker.match_pixel(beat);
        end
    end

    initial begin : stimulus
        int       rand_count;
        int       w;
        int       h;
        int       run_len;
        t_pattern pattern;

        frame_tracker = new();
        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
        widen_pending    = 1'b0;

        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= wsf_pkg::CFG_IMAGE_WIDTH;
        i_cfg_data         <= '0;
        pix_ch.valid       <= 1'b0;
        pix_ch.pixel_in    <= '0;
        pix_ch.frame_start <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. Sizes below three and a weight below four must saturate, so the
        // frame is 3x3 and the only computed pixel is its centre.
        write_cfg(wsf_pkg::CFG_IMAGE_WIDTH, 12'd0);
        write_cfg(wsf_pkg::CFG_IMAGE_HEIGHT, 12'd2);
        write_cfg(wsf_pkg::CFG_CENTER_WEIGHT, 12'd0);
        write_cfg(CFG_SPARE, 12'hFFF);
        for (int k = 0; k < 9; k++) send_pixel(k[0] ? 8'hFF : 8'h00, k == 0);
        drain_results();

        // Heaviest centre; the data bits above the weight field must be ignored. This
        // frame opens by the wrap at the end of the previous one, without a frame start.
        write_cfg(wsf_pkg::CFG_CENTER_WEIGHT, 12'hFFF);
        for (int k = 0; k < 9; k++) send_pixel(8'hFF, 1'b0);

        // A frame start in the middle of a frame restarts the position.
        send_pixel(8'h80, 1'b0);
        send_pixel(8'h7F, 1'b0);
        send_pixel(8'h01, 1'b1);
        send_pixel(8'hFE, 1'b0);
        drain_results();

        // An all-ones height saturates to the tallest frame, so a short run of a narrow
        // frame never reaches the bottom row.
        write_cfg(wsf_pkg::CFG_IMAGE_WIDTH, 12'd3);
        write_cfg(wsf_pkg::CFG_IMAGE_HEIGHT, 12'hFFF);
        write_cfg(wsf_pkg::CFG_CENTER_WEIGHT, 12'd5);
        send_run(3, wsf_pkg::MAX_HEIGHT, 15, PAT_RANDOM, 1'b1, 0);

        // Random part: small frames under changing settings. A run may stop mid-frame,
        // and the next one may carry on without a frame start, so a shrunk size catches
        // the position outside the frame.
        rand_count = 0;
        while (rand_count < RANDOM_ITEMS) begin
            drain_results();
            sender_no_idle   = ($urandom_range(0, 3) == 0);
            receiver_no_idle = ($urandom_range(0, 3) == 0);
            write_cfg(wsf_pkg::CFG_IMAGE_WIDTH,
                      wsf_pkg::CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                           $urandom_range(0, 2) : $urandom_range(3, 8)));
            write_cfg(wsf_pkg::CFG_IMAGE_HEIGHT,
                      wsf_pkg::CFG_DATA_W'(($urandom_range(0, 7) == 0) ?
                                           $urandom_range(0, 2) : $urandom_range(3, 6)));
            write_cfg(wsf_pkg::CFG_CENTER_WEIGHT,
                      wsf_pkg::CFG_DATA_W'($urandom_range(0, 4095)));
            w = frame_tracker.bound_size(frame_tracker.width_reg, wsf_pkg::MAX_WIDTH);
            h = frame_tracker.bound_size(frame_tracker.height_reg, wsf_pkg::MAX_HEIGHT);
            run_len = w * h * $urandom_range(1, 2);
            if ($urandom_range(0, 2) == 0) run_len = $urandom_range(1, run_len);
            pattern = ($urandom_range(0, 5) > 3) ? t_pattern'($urandom_range(1, 3)) : PAT_RANDOM;
            send_run(w, h, run_len, pattern, $urandom_range(0, 1), 40);
            rand_count += run_len;
        end

        sender_no_idle   = 1'b0;
        receiver_no_idle = 1'b0;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (frame_tracker.errors == 0 && frame_tracker.pending() == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
sv/wsf_pkg.sv
sv/wsf_pix_if.sv
sv/wsf_res_if.sv
sv/wsf_front.sv
sv/wsf_queue.sv
sv/wsf_back.sv
sv/weighted_3x3_smoothing_filter_unit.sv
dv/tb.sv
